[hw/rtl/rtnh_pkg.sv]
// ----------------------------------------------------------------------------
// rtnh_pkg
// Shared types, constants and the multiply-accumulate program of the
// nearest ray/triangle hit engine.
// ----------------------------------------------------------------------------
package rtnh_pkg;

  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int FRAC_BITS_DEF     = 12;

  localparam int CRD_W    = 32;            // stored coordinate
  localparam int EDGE_W   = CRD_W + 1;     // corner difference
  localparam int HALF_W   = 34;            // low slice of a minor
  localparam int MINOR_W  = 2 * EDGE_W + 1;
  localparam int MUL_B_W  = HALF_W + 1;
  localparam int PROD_W   = EDGE_W + MUL_B_W;
  localparam int DET_W    = 104;
  localparam int DIV_W    = DET_W + 31;
  localparam int DIST_W   = 31;
  localparam int OIDX_W   = 8;
  localparam int CNT_W    = 9;
  localparam int NSTEP    = 42;
  localparam int STEP_W   = 6;
  localparam int DIV_STEPS = 31;
  localparam int DCNT_W   = 5;
  localparam int DIST_RESET_INT = 90000;
  localparam logic [DIST_W-1:0] T_SAT = '1;

  localparam logic OP_CORNER = 1'b0;
  localparam logic OP_TRACE  = 1'b1;

  localparam logic [1:0] CORNER_A    = 2'd0;
  localparam logic [1:0] CORNER_B    = 2'd1;
  localparam logic [1:0] CORNER_C    = 2'd2;
  localparam logic [1:0] CORNER_NONE = 2'd3;

  localparam logic CFG_TRI_COUNT = 1'b0;
  localparam logic CFG_MAX_DIST  = 1'b1;

  // operand vectors, three components each
  localparam int V_AB  = 0;
  localparam int V_AC  = 1;
  localparam int V_AO  = 2;
  localparam int V_DIR = 3;
  localparam int NVEC  = 12;
  localparam int NMINOR = 9;

  localparam int DET_D = 0;
  localparam int DET_T = 1;
  localparam int DET_B = 2;
  localparam int DET_G = 3;
  localparam int DEST_DET0 = 9;

  typedef struct packed {
    logic [3:0] a_sel;
    logic       b_minor;
    logic [3:0] b_sel;
    logic       b_hi;
    logic       first;
    logic       sub;
    logic       store;
    logic [3:0] dest;
  } step_t;

  typedef struct packed {
    logic              ray_load;
    logic              corner_wr;
    logic              rd_en;
    logic [1:0]        rd_corner;
    logic              cap_en;
    logic [1:0]        cap_corner;
    logic              edge_calc;
    logic              mac_en;
    logic [STEP_W-1:0] step;
    logic              sign_fix;
    logic              div_start;
    logic              div_step;
    logic              commit;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic cand;
  } sts_t;

  // Cross products ac x dir, ac x ao, ao x dir into minors, then
  // d = ab.(ac x dir), dt = ab.(ac x ao), db = ao.(ac x dir), dg = ab.(ao x dir).
  function automatic step_t step_decode(input logic [STEP_W-1:0] idx);
    step_t s;
    int    n;
    int    qv;
    int    sv;
    int    pv;
    int    ms;
    int    i1;
    int    i2;
    s = '0;
    n = 0;
    for (int c = 0; c < 3; c++) begin
      qv = (c == 2) ? V_AO : V_AC;
      sv = (c == 1) ? V_AO : V_DIR;
      for (int k = 0; k < 3; k++) begin
        i1 = (k + 1) % 3;
        i2 = (k + 2) % 3;
        if (int'(idx) == n) begin
          s.a_sel = 4'(qv * 3 + i1);
          s.b_sel = 4'(sv * 3 + i2);
          s.first = 1'b1;
        end
        n++;
        if (int'(idx) == n) begin
          s.a_sel = 4'(qv * 3 + i2);
          s.b_sel = 4'(sv * 3 + i1);
          s.sub   = 1'b1;
          s.store = 1'b1;
          s.dest  = 4'(c * 3 + k);
        end
        n++;
      end
    end
    for (int j = 0; j < 4; j++) begin
      pv = (j == 2) ? V_AO : V_AB;
      ms = (j == 1) ? 1 : ((j == 3) ? 2 : 0);
      for (int k = 0; k < 3; k++) begin
        if (int'(idx) == n) begin
          s.a_sel   = 4'(pv * 3 + k);
          s.b_minor = 1'b1;
          s.b_sel   = 4'(ms * 3 + k);
          s.first   = (k == 0);
        end
        n++;
        if (int'(idx) == n) begin
          s.a_sel   = 4'(pv * 3 + k);
          s.b_minor = 1'b1;
          s.b_sel   = 4'(ms * 3 + k);
          s.b_hi    = 1'b1;
          s.store   = (k == 2);
          s.dest    = 4'(DEST_DET0 + j);
        end
        n++;
      end
    end
    return s;
  endfunction

endpackage

[hw/rtl/ray_triangle_nearest_hit.sv]
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit
// Nearest ray/triangle hit engine over a table of stored triangle corners.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | start / busy           | in_op, in_tri_index, in_corner, in_v*, in_o*, in_d*
//  result   | out_valid (strobe)     | out_hit, out_hit_index, out_hit_distance
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  A corner write is taken in the idle state and leaves busy low.
//  A trace walks each triangle through the corner reads, the shared 33x35 multiply-accumulate
//  program (42 beats) and, for a candidate hit only, the 31-step restoring divider;
//  the result strobe follows the last triangle.
//  Reset is synchronous; the corner table is not cleared and needs no sweep.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit import rtnh_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic [OIDX_W-1:0]       in_tri_index,
  input  logic [1:0]              in_corner,
  input  logic signed [CRD_W-1:0] in_vx,
  input  logic signed [CRD_W-1:0] in_vy,
  input  logic signed [CRD_W-1:0] in_vz,
  input  logic signed [CRD_W-1:0] in_ox,
  input  logic signed [CRD_W-1:0] in_oy,
  input  logic signed [CRD_W-1:0] in_oz,
  input  logic signed [CRD_W-1:0] in_dx,
  input  logic signed [CRD_W-1:0] in_dy,
  input  logic signed [CRD_W-1:0] in_dz,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [OIDX_W-1:0]       out_hit_index,
  output logic [DIST_W-1:0]       out_hit_distance,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [DIST_W-1:0]       cfg_data
);

  localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam longint DIST_RAW = longint'(DIST_RESET_INT) << FRAC_BITS;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET =
    (DIST_RAW > longint'(T_SAT)) ? T_SAT : DIST_W'(DIST_RAW);

  logic [CNT_W-1:0]  tri_count_r;
  logic [DIST_W-1:0] max_dist_r;
  cmd_t              cmd;
  sts_t              sts;
  logic [IW-1:0]     tri_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_count_r <= '0;
      max_dist_r  <= MAX_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TRI_COUNT: tri_count_r <= cfg_data[CNT_W-1:0];
        CFG_MAX_DIST:  max_dist_r  <= cfg_data;
        default:       tri_count_r <= tri_count_r;
      endcase
    end
  end

  rtnh_ctrl #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .tri_count (tri_count_r),
    .sts       (sts),
    .cmd       (cmd),
    .tri_idx   (tri_idx),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rtnh_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .tri_idx          (tri_idx),
    .sts              (sts),
    .max_distance     (max_dist_r),
    .in_tri_index     (in_tri_index),
    .in_corner        (in_corner),
    .in_vx            (in_vx),
    .in_vy            (in_vy),
    .in_vz            (in_vz),
    .in_ox            (in_ox),
    .in_oy            (in_oy),
    .in_oz            (in_oz),
    .in_dx            (in_dx),
    .in_dy            (in_dy),
    .in_dz            (in_dz),
    .out_hit          (out_hit),
    .out_hit_index    (out_hit_index),
    .out_hit_distance (out_hit_distance)
  );

endmodule

[hw/rtl/rtnh_ram.sv]
// ----------------------------------------------------------------------------
// rtnh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rtnh_dp.sv]
// ----------------------------------------------------------------------------
// rtnh_dp
// Datapath: corner store, edge vectors, shared multiply-accumulate unit,
// determinant tests, restoring divider and nearest-hit tracking.
// ----------------------------------------------------------------------------
module rtnh_dp import rtnh_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
  localparam int DEPTH = 3 * MAX_TRIANGLES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [IW-1:0]            tri_idx,
  output sts_t                     sts,
  input  logic [DIST_W-1:0]        max_distance,
  input  logic [OIDX_W-1:0]        in_tri_index,
  input  logic [1:0]               in_corner,
  input  logic signed [CRD_W-1:0]  in_vx,
  input  logic signed [CRD_W-1:0]  in_vy,
  input  logic signed [CRD_W-1:0]  in_vz,
  input  logic signed [CRD_W-1:0]  in_ox,
  input  logic signed [CRD_W-1:0]  in_oy,
  input  logic signed [CRD_W-1:0]  in_oz,
  input  logic signed [CRD_W-1:0]  in_dx,
  input  logic signed [CRD_W-1:0]  in_dy,
  input  logic signed [CRD_W-1:0]  in_dz,
  output logic                     out_hit,
  output logic [OIDX_W-1:0]        out_hit_index,
  output logic [DIST_W-1:0]        out_hit_distance
);

  logic signed [CRD_W-1:0]   org_r [3];
  logic signed [CRD_W-1:0]   dir_r [3];
  logic signed [CRD_W-1:0]   corner_r [3][3];
  logic signed [EDGE_W-1:0]  vec_r [NVEC];
  logic signed [MINOR_W-1:0] minor_r [NMINOR];
  logic signed [DET_W-1:0]   det_r [4];
  logic signed [DET_W-1:0]   acc_r;
  logic signed [PROD_W-1:0]  prod_r;
  step_t                     tag_r;
  logic                      tv_r;
  logic [DIV_W-1:0]          rem_r;
  logic [DIV_W-1:0]          den_r;
  logic [DIST_W-1:0]         q_r;
  logic                      sat_r;
  logic [DIST_W-1:0]         best_r;
  logic [OIDX_W-1:0]         idx_r;
  logic                      found_r;
  logic                      out_hit_r;
  logic [OIDX_W-1:0]         out_idx_r;
  logic [DIST_W-1:0]         out_dist_r;

  logic [31:0]               waddr_full;
  logic [31:0]               raddr_full;
  logic                      wr_ok;
  logic [3*CRD_W-1:0]        rdata;
  step_t                     st;
  logic signed [MINOR_W-1:0] mc;
  logic signed [EDGE_W-1:0]  a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [DET_W-1:0]   term;
  logic signed [DET_W-1:0]   acc_nxt;
  logic signed [DET_W:0]     bg_sum;
  logic [DIV_W-1:0]          num;
  logic [DIV_W-1:0]          den;
  logic [DIV_W-1:0]          den_sh;
  logic                      ge;
  logic [DIST_W-1:0]         t_val;

  assign waddr_full = 32'(in_tri_index) * 32'd3 + 32'(in_corner);
  assign raddr_full = 32'(tri_idx) * 32'd3 + 32'(cmd.rd_corner);
  assign wr_ok = cmd.corner_wr && (in_corner != CORNER_NONE)
                 && (32'(in_tri_index) < 32'(MAX_TRIANGLES));

  rtnh_ram #(
    .WIDTH (3 * CRD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (waddr_full[AW-1:0]),
    .wdata ({in_vz, in_vy, in_vx}),
    .re    (cmd.rd_en),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    st   = step_decode(cmd.step);
    a_op = vec_r[st.a_sel];
    mc   = minor_r[st.b_sel];
    if (!st.b_minor) begin
      b_op = MUL_B_W'(vec_r[st.b_sel]);
    end else if (st.b_hi) begin
      b_op = MUL_B_W'($signed(mc[MINOR_W-1:HALF_W]));
    end else begin
      b_op = $signed({1'b0, mc[HALF_W-1:0]});
    end
    prod_nxt = a_op * b_op;
  end

  always_comb begin
    term    = tag_r.b_hi ? (DET_W'(prod_r) <<< HALF_W) : DET_W'(prod_r);
    acc_nxt = (tag_r.first ? '0 : acc_r) + (tag_r.sub ? -term : term);
  end

  always_comb begin
    bg_sum   = (DET_W + 1)'(det_r[DET_B]) + (DET_W + 1)'(det_r[DET_G]);
    sts.cand = (det_r[DET_D] != '0) && !det_r[DET_T][DET_W-1] && (det_r[DET_T] != '0)
               && !det_r[DET_B][DET_W-1] && !det_r[DET_G][DET_W-1]
               && (bg_sum <= (DET_W + 1)'(det_r[DET_D]));
    num    = DIV_W'($unsigned(det_r[DET_T])) << FRAC_BITS;
    den    = DIV_W'($unsigned(det_r[DET_D])) << DIV_STEPS;
    den_sh = den_r >> 1;
    ge     = rem_r >= den_sh;
    t_val  = sat_r ? T_SAT : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= cmd.mac_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ray_load) begin
      org_r[0] <= in_ox;
      org_r[1] <= in_oy;
      org_r[2] <= in_oz;
      dir_r[0] <= in_dx;
      dir_r[1] <= in_dy;
      dir_r[2] <= in_dz;
      best_r   <= max_distance;
      idx_r    <= '0;
      found_r  <= 1'b0;
    end
    if (cmd.cap_en) begin
      corner_r[cmd.cap_corner][0] <= rdata[CRD_W-1:0];
      corner_r[cmd.cap_corner][1] <= rdata[2*CRD_W-1:CRD_W];
      corner_r[cmd.cap_corner][2] <= rdata[3*CRD_W-1:2*CRD_W];
    end
    if (cmd.edge_calc) begin
      for (int k = 0; k < 3; k++) begin
        vec_r[V_AB*3+k]  <= EDGE_W'(corner_r[0][k]) - EDGE_W'(corner_r[1][k]);
        vec_r[V_AC*3+k]  <= EDGE_W'(corner_r[0][k]) - EDGE_W'(corner_r[2][k]);
        vec_r[V_AO*3+k]  <= EDGE_W'(corner_r[0][k]) - EDGE_W'(org_r[k]);
        vec_r[V_DIR*3+k] <= EDGE_W'(dir_r[k]);
      end
    end
    prod_r <= prod_nxt;
    tag_r  <= st;
    if (tv_r) begin
      acc_r <= acc_nxt;
      if (tag_r.store) begin
        if (tag_r.dest < 4'(DEST_DET0)) begin
          minor_r[tag_r.dest] <= acc_nxt[MINOR_W-1:0];
        end else begin
          det_r[2'(tag_r.dest - 4'(DEST_DET0))] <= acc_nxt;
        end
      end
    end
    if (cmd.sign_fix && det_r[DET_D][DET_W-1]) begin
      for (int i = 0; i < 4; i++) begin
        det_r[i] <= -det_r[i];
      end
    end
    if (cmd.div_start) begin
      rem_r <= num;
      den_r <= den;
      sat_r <= num >= den;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_r - den_sh : rem_r;
      den_r <= den_sh;
      q_r   <= {q_r[DIST_W-2:0], ge};
    end
    if (cmd.commit && (t_val < best_r)) begin
      best_r  <= t_val;
      idx_r   <= OIDX_W'(tri_idx);
      found_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_hit_r  <= found_r;
      out_idx_r  <= found_r ? idx_r : '0;
      out_dist_r <= found_r ? best_r : '0;
    end
  end

  assign out_hit          = out_hit_r;
  assign out_hit_index    = out_idx_r;
  assign out_hit_distance = out_dist_r;

endmodule

[hw/rtl/rtnh_ctrl.sv]
// ----------------------------------------------------------------------------
// rtnh_ctrl
// Controller: walks the triangles of one ray, sequences corner reads, the
// multiply-accumulate program, the divider and the result beat.
// ----------------------------------------------------------------------------
module rtnh_ctrl import rtnh_pkg::*; #(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
  localparam int CT = $clog2(MAX_TRIANGLES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_op,
  input  logic [CNT_W-1:0] tri_count,
  input  sts_t             sts,
  output cmd_t             cmd,
  output logic [IW-1:0]    tri_idx,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_RDC, S_CAPC, S_EDGE, S_MAC, S_DRAIN,
    S_FIX, S_TEST, S_DIV, S_COMMIT, S_NEXT, S_DONE
  } state_t;

  state_t            state_r;
  logic [CT-1:0]     tri_r;
  logic [STEP_W-1:0] step_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              out_valid_r;
  logic [31:0]       n_tri;

  assign n_tri = (32'(tri_count) > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES)
                                                       : 32'(tri_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tri_r       <= '0;
      step_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start && (in_op == OP_TRACE)) begin
            tri_r   <= '0;
            state_r <= (n_tri == 32'd0) ? S_DONE : S_RDA;
          end
        end
        S_RDA:  state_r <= S_RDB;
        S_RDB:  state_r <= S_RDC;
        S_RDC:  state_r <= S_CAPC;
        S_CAPC: state_r <= S_EDGE;
        S_EDGE: begin
          step_r  <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(NSTEP - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_FIX;
        S_FIX:   state_r <= S_TEST;
        S_TEST: begin
          dcnt_r  <= '0;
          state_r <= sts.cand ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: state_r <= S_NEXT;
        S_NEXT: begin
          if (32'(tri_r) + 32'd1 >= n_tri) begin
            state_r <= S_DONE;
          end else begin
            tri_r   <= tri_r + 1'b1;
            state_r <= S_RDA;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.step       = step_r;
    cmd.ray_load   = (state_r == S_IDLE) && start && (in_op == OP_TRACE);
    cmd.corner_wr  = (state_r == S_IDLE) && start && (in_op == OP_CORNER);
    cmd.rd_en      = (state_r == S_RDA) || (state_r == S_RDB) || (state_r == S_RDC);
    cmd.rd_corner  = (state_r == S_RDA) ? CORNER_A :
                     (state_r == S_RDB) ? CORNER_B : CORNER_C;
    cmd.cap_en     = (state_r == S_RDB) || (state_r == S_RDC) || (state_r == S_CAPC);
    cmd.cap_corner = (state_r == S_RDB) ? CORNER_A :
                     (state_r == S_RDC) ? CORNER_B : CORNER_C;
    cmd.edge_calc  = (state_r == S_EDGE);
    cmd.mac_en     = (state_r == S_MAC);
    cmd.sign_fix   = (state_r == S_FIX);
    cmd.div_start  = (state_r == S_TEST) && sts.cand;
    cmd.div_step   = (state_r == S_DIV);
    cmd.commit     = (state_r == S_COMMIT);
    cmd.emit       = (state_r == S_DONE);
  end

  assign tri_idx   = tri_r[IW-1:0];
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == S_DONE)
    else $error("result strobe without finishing a ray");

  a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDA) |-> (32'(tri_r) < n_tri))
    else $error("triangle index beyond count");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (step_r < STEP_W'(NSTEP)))
    else $error("multiply program overrun");

endmodule

[tb/ray_triangle_nearest_hit_tb.sv]
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_tb
// Self-checking bench for the nearest ray/triangle hit engine. A queue-fed
// driver sends corner writes and traces with random gaps, a monitor checks each
// result strobe against a local Cramer's-rule predictor with exact wide math.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_triangle_nearest_hit_tb;
  import rtnh_pkg::*;

  localparam int NTRI      = MAX_TRIANGLES_DEF;
  localparam int IDLE_LIMIT = 200000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic                    op;
    logic [OIDX_W-1:0]       slot;
    logic [1:0]              corner;
    logic signed [CRD_W-1:0] v [3];
    logic signed [CRD_W-1:0] o [3];
    logic signed [CRD_W-1:0] d [3];
  } beat_t;

  typedef struct {
    logic              hit;
    logic [OIDX_W-1:0] index;
    logic [DIST_W-1:0] distance;
  } hit_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_op;
  logic [OIDX_W-1:0] in_tri_index;
  logic [1:0] in_corner;
  logic signed [CRD_W-1:0] in_vx, in_vy, in_vz, in_ox, in_oy, in_oz, in_dx, in_dy, in_dz;
  logic out_valid;
  logic out_hit;
  logic [OIDX_W-1:0] out_hit_index;
  logic [DIST_W-1:0] out_hit_distance;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [DIST_W-1:0] cfg_data;

  ray_triangle_nearest_hit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_tri_index(in_tri_index), .in_corner(in_corner),
    .in_vx(in_vx), .in_vy(in_vy), .in_vz(in_vz),
    .in_ox(in_ox), .in_oy(in_oy), .in_oz(in_oz),
    .in_dx(in_dx), .in_dy(in_dy), .in_dz(in_dz),
    .out_valid(out_valid), .out_hit(out_hit), .out_hit_index(out_hit_index),
    .out_hit_distance(out_hit_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic signed [CRD_W-1:0] corner_mem [NTRI][3][3];
  logic [CNT_W-1:0]  tri_count_reg;
  logic [DIST_W-1:0] max_dist_reg;
  hit_t              nearest_q [$];

  // stimulus side copy of the table, used to aim rays
  logic signed [CRD_W-1:0] gen_mem [NTRI][3][3];
  bit                      gen_seen [NTRI][3];

  beat_t pending_q [$];
  beat_t cur;
  int    errors;
  int    gap;
  int    burst_left;
  int    idle_cycles;
  bit    nxt_start;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic wide_t det3(input wide_t p [3], input wide_t q [3], input wide_t s [3]);
    return p[0] * (q[1] * s[2] - s[1] * q[2]) + p[1] * (s[0] * q[2] - q[0] * s[2])
         + p[2] * (q[0] * s[1] - q[1] * s[0]);
  endfunction

  function automatic hit_t trace_nearest(input beat_t b);
    wide_t ab [3];
    wide_t ac [3];
    wide_t ao [3];
    wide_t dv [3];
    wide_t dd, dt, db, dg, quo;
    logic [DIST_W-1:0] t;
    hit_t r;
    int n;
    r.hit = 1'b0;
    r.index = '0;
    r.distance = max_dist_reg;
    n = (tri_count_reg > NTRI) ? NTRI : int'(tri_count_reg);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        ab[k] = corner_mem[i][0][k];
        ab[k] = ab[k] - corner_mem[i][1][k];
        ac[k] = corner_mem[i][0][k];
        ac[k] = ac[k] - corner_mem[i][2][k];
        ao[k] = corner_mem[i][0][k];
        ao[k] = ao[k] - b.o[k];
        dv[k] = b.d[k];
      end
      dd = det3(ab, ac, dv);
      if (dd == 0) continue;
      dt = det3(ab, ac, ao);
      db = det3(ao, ac, dv);
      dg = det3(ab, ao, dv);
      if (dd < 0) begin
        dd = -dd;
        dt = -dt;
        db = -db;
        dg = -dg;
      end
      if (dt <= 0 || db < 0 || dg < 0 || db + dg > dd) continue;
      quo = (dt <<< FRAC_BITS_DEF) / dd;
      t = (quo >= (wide_t'(1) <<< 31)) ? T_SAT : quo[DIST_W-1:0];
      if (t < r.distance) begin
        r.hit = 1'b1;
        r.index = OIDX_W'(i);
        r.distance = t;
      end
    end
    if (!r.hit) r.distance = '0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      nxt_start = start;
      if (start && !busy) begin
        if (cur.op == OP_TRACE) begin
          nearest_q.push_back(trace_nearest(cur));
        end else if (cur.corner != CORNER_NONE) begin
          for (int k = 0; k < 3; k++) corner_mem[cur.slot][cur.corner][k] = cur.v[k];
        end
        nxt_start = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          burst_left = $urandom_range(10, 40);
          gap = 0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(8, 60);
          endcase
        end
      end
      if (!nxt_start) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_op <= cur.op;
          in_tri_index <= cur.slot;
          in_corner <= cur.corner;
          in_vx <= cur.v[0];
          in_vy <= cur.v[1];
          in_vz <= cur.v[2];
          in_ox <= cur.o[0];
          in_oy <= cur.o[1];
          in_oz <= cur.o[2];
          in_dx <= cur.d[0];
          in_dy <= cur.d[1];
          in_dz <= cur.d[2];
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid) begin
      if (nearest_q.size() == 0) begin
        report_mismatch("unexpected result, hit", out_hit, 0);
      end else begin
        want = nearest_q.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_hit_index !== want.index)
          report_mismatch("hit_index", out_hit_index, want.index);
        if (out_hit_distance !== want.distance)
          report_mismatch("hit_distance", out_hit_distance, want.distance);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic beat_t blank_beat();
    beat_t b;
    b.op = OP_CORNER;
    b.slot = '0;
    b.corner = CORNER_A;
    for (int k = 0; k < 3; k++) begin
      b.v[k] = '0;
      b.o[k] = '0;
      b.d[k] = '0;
    end
    return b;
  endfunction

  function automatic int fx(input int n);
    return n <<< FRAC_BITS_DEF;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
  endfunction

  task automatic add_corner(input int slot, input logic [1:0] c, input int x, input int y,
                            input int z);
    beat_t b;
    b = blank_beat();
    b.slot = OIDX_W'(slot);
    b.corner = c;
    b.v[0] = x;
    b.v[1] = y;
    b.v[2] = z;
    for (int k = 0; k < 3; k++) b.o[k] = $urandom;
    for (int k = 0; k < 3; k++) b.d[k] = $urandom;
    if (c != CORNER_NONE) begin
      for (int k = 0; k < 3; k++) gen_mem[slot][c][k] = b.v[k];
      gen_seen[slot][c] = 1'b1;
    end
    pending_q.push_back(b);
  endtask

  task automatic add_trace(input int ox, input int oy, input int oz, input int dx,
                           input int dy, input int dz);
    beat_t b;
    b = blank_beat();
    b.op = OP_TRACE;
    b.slot = OIDX_W'($urandom);
    b.corner = 2'($urandom);
    for (int k = 0; k < 3; k++) b.v[k] = $urandom;
    b.o[0] = ox;
    b.o[1] = oy;
    b.o[2] = oz;
    b.d[0] = dx;
    b.d[1] = dy;
    b.d[2] = dz;
    pending_q.push_back(b);
  endtask

  task automatic rand_tri(input int slot);
    logic [1:0] order [3];
    order = '{CORNER_A, CORNER_B, CORNER_C};
    if ($urandom_range(0, 1)) order = '{CORNER_C, CORNER_A, CORNER_B};
    for (int c = 0; c < 3; c++)
      add_corner(slot, order[c], rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // aim at a weighted point of the triangle, edges and corners included
  task automatic aim_trace(input int slot);
    longint p [3];
    longint o [3];
    int wa, wb, wc, sh;
    wa = $urandom_range(0, 4);
    wb = $urandom_range(0, 4);
    wc = $urandom_range(0, 4);
    if (wa + wb + wc == 0) wa = 1;
    sh = $urandom_range(0, 6);
    for (int k = 0; k < 3; k++) begin
      p[k] = (wa * longint'(gen_mem[slot][0][k]) + wb * longint'(gen_mem[slot][1][k])
            + wc * longint'(gen_mem[slot][2][k])) / (wa + wb + wc);
      o[k] = rnd_coord();
    end
    add_trace(int'(o[0]), int'(o[1]), int'(o[2]), int'((p[0] - o[0]) >>> sh),
              int'((p[1] - o[1]) >>> sh), int'((p[2] - o[2]) >>> sh));
  endtask

  task automatic noise_beat();
    beat_t b;
    b = blank_beat();
    b.op = 1'($urandom);
    b.slot = OIDX_W'($urandom);
    b.corner = 2'($urandom);
    for (int k = 0; k < 3; k++) begin
      b.v[k] = $urandom;
      b.o[k] = $urandom;
      b.d[k] = $urandom;
    end
    if (b.op == OP_CORNER && b.corner != CORNER_NONE) begin
      for (int k = 0; k < 3; k++) gen_mem[b.slot][b.corner][k] = b.v[k];
      gen_seen[b.slot][b.corner] = 1'b1;
    end
    pending_q.push_back(b);
  endtask

  function automatic int written_prefix();
    for (int i = 0; i < NTRI; i++)
      if (!(gen_seen[i][0] && gen_seen[i][1] && gen_seen[i][2])) return i;
    return NTRI;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || start || nearest_q.size() > 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DIST_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TRI_COUNT) tri_count_reg = data[CNT_W-1:0];
    else max_dist_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    int r;
    int sent;
    errors = 0;
    gap = 0;
    burst_left = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_CORNER;
    in_tri_index = '0;
    in_corner = CORNER_A;
    {in_vx, in_vy, in_vz, in_ox, in_oy, in_oz, in_dx, in_dy, in_dz} = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TRI_COUNT;
    cfg_data = '0;
    tri_count_reg = '0;
    max_dist_reg = DIST_W'(DIST_RESET_INT * (1 << FRAC_BITS_DEF));
    for (int i = 0; i < NTRI; i++)
      for (int c = 0; c < 3; c++) begin
        gen_seen[i][c] = 1'b0;
        for (int k = 0; k < 3; k++) begin
          corner_mem[i][c][k] = '0;
          gen_mem[i][c][k] = '0;
        end
      end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: right triangles with legs of 4 in planes z=10 and z=5, the latter twice for a tie
    add_corner(0, CORNER_A, 0, 0, fx(10));
    add_corner(0, CORNER_B, fx(4), 0, fx(10));
    add_corner(0, CORNER_C, 0, fx(4), fx(10));
    add_corner(0, CORNER_NONE, 32'sh7fff_ffff, 32'sh8000_0000, -1);
    add_trace(fx(1), fx(1), 0, 0, 0, fx(1));
    drain();
    write_reg(CFG_TRI_COUNT, DIST_W'(1));
    add_trace(fx(1), fx(1), 0, 0, 0, fx(1));
    add_trace(fx(2), fx(2), 0, 0, 0, fx(1));
    add_trace(fx(1), fx(1), 0, fx(1), 0, 0);
    add_trace(fx(1), fx(1), 0, 0, 0, -fx(1));
    add_trace(fx(1), fx(1), fx(10), 0, 0, fx(1));
    add_trace(-fx(1), fx(1), 0, 0, 0, fx(1));
    add_trace(fx(3), fx(3), 0, 0, 0, fx(1));
    add_trace(fx(1), fx(1), -fx(990), 0, 0, 1);
    add_trace(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000);
    add_trace(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh7fff_ffff);
    for (int i = 1; i < 3; i++) begin
      add_corner(i, CORNER_C, 0, fx(4), fx(5));
      add_corner(i, CORNER_B, fx(4), 0, fx(5));
      add_corner(i, CORNER_A, 0, 0, fx(5));
    end
    drain();
    write_reg(CFG_TRI_COUNT, DIST_W'(3));
    add_trace(fx(1), fx(1), 0, 0, 0, fx(1));
    add_trace(fx(1), fx(1), fx(7), 0, 0, fx(1));
    drain();
    write_reg(CFG_MAX_DIST, DIST_W'(0));
    add_trace(fx(1), fx(1), 0, 0, 0, fx(1));
    drain();
    write_reg(CFG_MAX_DIST, DIST_W'(fx(5)));
    add_trace(fx(1), fx(1), 0, 0, 0, fx(1));
    add_trace(fx(1), fx(1), 0, 0, 0, fx(2));
    drain();
    write_reg(CFG_MAX_DIST, T_SAT);
    add_trace(fx(1), fx(1), -fx(990), 0, 0, 1);

    // random groups: fresh triangles, a setting, then mostly aimed rays
    sent = 0;
    while (sent < 540) begin
      n = $urandom_range(1, 10);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 2) == 0 || written_prefix() <= j) begin
          rand_tri(j);
          sent += 3;
        end
      end
      drain();
      n = $urandom_range(1, (written_prefix() > 12) ? 12 : written_prefix());
      write_reg(CFG_TRI_COUNT, DIST_W'(n));
      r = $urandom_range(0, 9);
      if (r < 3) write_reg(CFG_MAX_DIST, T_SAT);
      else if (r < 5) write_reg(CFG_MAX_DIST, DIST_W'($urandom));
      else if (r < 6) write_reg(CFG_MAX_DIST, DIST_W'(0));
      else write_reg(CFG_MAX_DIST, DIST_W'(DIST_RESET_INT * (1 << FRAC_BITS_DEF)));
      repeat ($urandom_range(5, 15)) begin
        r = $urandom_range(0, 19);
        if (r < 15) aim_trace($urandom_range(0, n - 1));
        else noise_beat();
        sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
